@@ rtl/pidc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// Types and constants shared by the PID controller with integral clamp.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int TGT_W      = 16;   // setpoint, whole lux
   localparam int MEAS_W     = 24;   // measured level, Q16.8
   localparam int DT_W       = 20;   // elapsed time, Q12.8 ms
   localparam int GAIN_W     = 32;   // gains, unsigned
   localparam int LIM_W      = 39;   // integral clamp magnitude
   localparam int ERR_W      = 26;   // signed error, Q.8
   localparam int EMAG_W     = 25;   // error magnitude
   localparam int DE_W       = 27;   // signed error difference
   localparam int INTG_W     = 40;   // signed integral, Q.8 lux*ms
   localparam int SUM_W      = 41;   // integral before clamping
   localparam int DMAG_W     = 34;   // derivative dividend / quotient magnitude
   localparam int CHUNK_W    = 20;   // multiplier A operand
   localparam int PROD_W     = CHUNK_W + GAIN_W;
   localparam int IPROD_W    = EMAG_W + DT_W;   // |error| * elapsed
   localparam int ACC_W      = 74;   // output accumulator, signed
   localparam int DRIVE_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 39;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LEVEL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_LIMIT = 3'd4;

   localparam logic [LIM_W-1:0] LIMIT_RESET = 39'd25600000;

   typedef struct packed {
      logic [MEAS_W-1:0] measured_level;
      logic [DT_W-1:0]   elapsed_ms;
   } req_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive_value;
      logic                      integral_clamped;
   } rsp_type;

endpackage

@@ rtl/pid_with_integral_clamp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_with_integral_clamp
// PID controller step with derivative divider and clamped integral.
// ----------------------------------------------------------------------------
// A request passes through a prepare state, the 34-step restoring divider
// that forms the derivative magnitude (skipped when elapsed_ms is zero), then
// the single shared 20x32 multiplier, which produces the error*time product
// and six gain partial products, each taking a multiply state and an
// accumulate state, with the integral clamp after the first. A new request is
// taken only once the previous result is loaded into the output register,
// which waits on rsp_ready. A finished result sits in the output register
// while the next request is already accepted.
module pid_with_integral_clamp
   import pidc_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [GAIN_W-1:0] GAIN_P_RESET = GAIN_W'(64'd1 << GAIN_FRAC_BITS);
   localparam logic [GAIN_W-1:0] GAIN_I_RESET =
      GAIN_W'((64'd1 << GAIN_FRAC_BITS) / 100);
   localparam logic [GAIN_W-1:0] GAIN_D_RESET =
      GAIN_W'((64'd1 << GAIN_FRAC_BITS) / 1000);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_ACC   = 3'd4;
   localparam logic [2:0] ST_CLAMP = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   localparam logic [2:0] STEP_INTEG = 3'd0;
   localparam logic [2:0] STEP_LAST  = 3'd6;
   localparam logic [5:0] DIV_LAST   = 6'(DMAG_W - 1);

   // configuration
   logic [TGT_W-1:0]  target_ff;
   logic [GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [LIM_W-1:0]  lim_ff;

   // controller state
   logic signed [ERR_W-1:0]  prev_ff;
   logic signed [INTG_W-1:0] intg_ff;

   // working registers
   logic [2:0]               state_ff;
   logic [2:0]               step_ff;
   logic [5:0]               cnt_ff;
   logic [DT_W-1:0]          dt_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic [EMAG_W-1:0]        err_mag_ff;
   logic                     err_neg_ff;
   logic [DMAG_W-1:0]        div_q_ff;
   logic [DT_W-1:0]          rem_ff;
   logic                     der_neg_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic [INTG_W-1:0]        sum_mag_ff;
   logic                     sum_neg_ff;
   logic                     clamp_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   // ---------------------------------------------------------------- datapath
   logic                     req_fire, csr_fire, out_load;
   logic signed [ERR_W-1:0]  err_in;
   logic signed [ERR_W-1:0]  err_abs;
   logic signed [DE_W-1:0]   de;
   logic signed [DE_W-1:0]   de_abs;
   logic [DMAG_W-1:0]        dmag;
   logic [DT_W:0]            trial;
   logic                     qbit;
   logic [CHUNK_W-1:0]       mul_a;
   logic [GAIN_W-1:0]        mul_b;
   logic                     term_neg;
   logic [ACC_W-1:0]         addend;
   logic signed [IPROD_W:0]  iprod;
   logic signed [IPROD_W:0]  iprod_sh;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  lim_s;
   logic signed [SUM_W-1:0]  neg_lim_s;
   logic signed [SUM_W-1:0]  sum_abs;
   logic signed [ACC_W-1:0]  acc_sh;
   logic [DRIVE_W-1:0]       drive;

   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign err_in  = $signed({2'b00, target_ff, 8'h00}) -
                    $signed({2'b00, req_data.measured_level});
   assign err_abs = err_ff[ERR_W-1] ? -err_ff : err_ff;
   assign de      = DE_W'(err_ff) - DE_W'(prev_ff);
   assign de_abs  = de[DE_W-1] ? -de : de;
   assign dmag    = {de_abs[DE_W-2:0], 8'h00};

   // one restoring divide step
   assign trial = {rem_ff, div_q_ff[DMAG_W-1]};
   assign qbit  = (trial >= {1'b0, dt_ff});

   // shared multiplier operand select
   always_comb begin
      mul_a    = '0;
      mul_b    = gain_p_ff;
      term_neg = 1'b0;
      unique case (step_ff)
         3'd0: begin
            mul_a = dt_ff;
            mul_b = GAIN_W'(err_mag_ff);
         end
         3'd1: begin
            mul_a    = err_mag_ff[CHUNK_W-1:0];
            term_neg = err_neg_ff;
         end
         3'd2: begin
            mul_a    = CHUNK_W'(err_mag_ff[EMAG_W-1:CHUNK_W]);
            term_neg = err_neg_ff;
         end
         3'd3: begin
            mul_a    = sum_mag_ff[CHUNK_W-1:0];
            mul_b    = gain_i_ff;
            term_neg = sum_neg_ff;
         end
         3'd4: begin
            mul_a    = sum_mag_ff[INTG_W-1:CHUNK_W];
            mul_b    = gain_i_ff;
            term_neg = sum_neg_ff;
         end
         3'd5: begin
            mul_a    = div_q_ff[CHUNK_W-1:0];
            mul_b    = gain_d_ff;
            term_neg = der_neg_ff;
         end
         3'd6: begin
            mul_a    = CHUNK_W'(div_q_ff[DMAG_W-1:CHUNK_W]);
            mul_b    = gain_d_ff;
            term_neg = der_neg_ff;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // high chunks (even steps) land CHUNK_W bits up
   assign addend = step_ff[0] ? ACC_W'(prod_ff) : (ACC_W'(prod_ff) << CHUNK_W);

   // integral increment: floor((err*dt)/256)
   assign iprod    = err_neg_ff ? -$signed({1'b0, prod_ff[IPROD_W-1:0]})
                                :  $signed({1'b0, prod_ff[IPROD_W-1:0]});
   assign iprod_sh = iprod >>> 8;
   assign sum_in   = SUM_W'(intg_ff) + iprod_sh[SUM_W-1:0];

   assign lim_s     = $signed({2'b00, lim_ff});
   assign neg_lim_s = -lim_s;
   assign sum_abs   = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;

   assign acc_sh = acc_ff >>> GAIN_FRAC_BITS;
   always_comb begin
      if ((&acc_sh[ACC_W-1:DRIVE_W-1]) || !(|acc_sh[ACC_W-1:DRIVE_W-1])) begin
         drive = acc_sh[DRIVE_W-1:0];
      end else if (acc_sh[ACC_W-1]) begin
         drive = {1'b1, {(DRIVE_W-1){1'b0}}};
      end else begin
         drive = {1'b0, {(DRIVE_W-1){1'b1}}};
      end
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         gain_p_ff <= GAIN_P_RESET;
         gain_i_ff <= GAIN_I_RESET;
         gain_d_ff <= GAIN_D_RESET;
         lim_ff    <= LIMIT_RESET;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_TARGET_LEVEL:   target_ff <= csr_wdata[TGT_W-1:0];
            CSR_GAIN_P:         gain_p_ff <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:         gain_i_ff <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:         gain_d_ff <= csr_wdata[GAIN_W-1:0];
            CSR_INTEGRAL_LIMIT: lim_ff    <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_INTEG;
         cnt_ff       <= '0;
         prev_ff      <= '0;
         intg_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               prev_ff  <= err_ff;
               step_ff  <= STEP_INTEG;
               cnt_ff   <= '0;
               state_ff <= (dt_ff != '0) ? ST_DIV : ST_MUL;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == DIV_LAST) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (step_ff == STEP_INTEG) begin
                  state_ff <= ST_CLAMP;
               end else if (step_ff == STEP_LAST) begin
                  state_ff <= ST_OUT;
               end else begin
                  step_ff  <= step_ff + 3'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_CLAMP: begin
               intg_ff <= (sum_ff > lim_s)     ? INTG_W'(lim_s) :
                          (sum_ff < neg_lim_s) ? INTG_W'(neg_lim_s) :
                                                 INTG_W'(sum_ff);
               step_ff  <= 3'd1;
               state_ff <= ST_MUL;
            end
            ST_OUT: begin
               if (out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // payload / working registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         dt_ff  <= req_data.elapsed_ms;
         err_ff <= err_in;
      end

      if (state_ff == ST_PREP) begin
         err_mag_ff <= err_abs[EMAG_W-1:0];
         err_neg_ff <= err_ff[ERR_W-1];
         div_q_ff   <= (dt_ff != '0) ? dmag : '0;
         der_neg_ff <= de[DE_W-1] && (dt_ff != '0);
         rem_ff     <= '0;
         acc_ff     <= '0;
      end

      if (state_ff == ST_DIV) begin
         rem_ff   <= qbit ? DT_W'(trial - {1'b0, dt_ff}) : trial[DT_W-1:0];
         div_q_ff <= {div_q_ff[DMAG_W-2:0], qbit};
      end

      if (state_ff == ST_MUL) begin
         prod_ff <= mul_a * mul_b;
      end

      if (state_ff == ST_ACC) begin
         if (step_ff == STEP_INTEG) begin
            sum_ff <= sum_in;
         end else begin
            acc_ff <= term_neg ? (acc_ff - $signed(addend))
                               : (acc_ff + $signed(addend));
         end
      end

      if (state_ff == ST_CLAMP) begin
         if (sum_ff > lim_s) begin
            sum_mag_ff <= INTG_W'(lim_ff);
            sum_neg_ff <= 1'b0;
            clamp_ff   <= 1'b1;
         end else if (sum_ff < neg_lim_s) begin
            sum_mag_ff <= INTG_W'(lim_ff);
            sum_neg_ff <= 1'b1;
            clamp_ff   <= 1'b1;
         end else begin
            sum_mag_ff <= sum_abs[INTG_W-1:0];
            sum_neg_ff <= sum_ff[SUM_W-1];
            clamp_ff   <= 1'b0;
         end
      end

      if (out_load) begin
         rsp_ff.drive_value      <= $signed(drive);
         rsp_ff.integral_clamped <= clamp_ff;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_PREP)
      else $error("accepted request did not start processing");

   a_integral_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLAMP |=> (SUM_W'(intg_ff) <= lim_s && SUM_W'(intg_ff) >= neg_lim_s))
      else $error("integral outside clamp limit");

   a_clamp_mag: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLAMP |=> (!clamp_ff || sum_mag_ff == INTG_W'(lim_ff)))
      else $error("clamped integral magnitude differs from limit");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < dt_ff)
      else $error("divider remainder not below divisor");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response raised outside output state");
`endif

endmodule
